### rtl/u8dec_pkg.sv
// Package for the UTF-8 codepoint decoder: types, constants and decode functions.
`default_nettype none

package u8dec_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 3;
    localparam int HELD_N = 4;

    localparam logic [CP_W-1:0]   REPL_CP    = 21'h00FFFD;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_VAL   = 8'h80;

    typedef logic [HELD_N-1:0][BYTE_W-1:0] t_held;

    // Outcome of one decode pass over the held bytes.
    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] cp;
        logic [CNT_W-1:0] drop;
    } t_eval;

    typedef struct packed {
        logic load;   // append the accepted word
        logic step;   // register the result and drop its bytes
        logic clear;  // pass gave no result; flush if end of text
    } t_dp_cmd;

    typedef struct packed {
        logic emit;   // current pass yields a result
        logic last;   // registered result is the last one of this word
    } t_dp_sts;

    function automatic t_eval eval_lead(t_held b, logic [CNT_W-1:0] cnt, logic eot);
        t_eval r;
        logic [1:0] need;
        logic valid_lead;
        logic bad;
        r.emit = 1'b0;
        r.cp = REPL_CP;
        r.drop = '0;
        need = 2'd0;
        valid_lead = 1'b1;
        bad = 1'b0;
        if (!b[0][7]) begin
            need = 2'd0;
        end else if ((b[0] & LEAD2_MASK) == LEAD2_VAL) begin
            need = 2'd1;
        end else if ((b[0] & LEAD3_MASK) == LEAD3_VAL) begin
            need = 2'd2;
        end else if ((b[0] & LEAD4_MASK) == LEAD4_VAL) begin
            need = 2'd3;
        end else begin
            valid_lead = 1'b0;
        end
        for (int i = 1; i < HELD_N; i++) begin
            if (i <= int'(need) && (b[i] & CONT_MASK) != CONT_VAL) begin
                bad = 1'b1;
            end
        end
        if (cnt == '0) begin
            r.emit = 1'b0;
        end else if (!valid_lead) begin
            r.emit = 1'b1;
            r.drop = 3'd1;
        end else if (cnt < ({1'b0, need} + 3'd1)) begin
            // incomplete: truncated at end of text covers all held bytes
            r.emit = eot;
            r.drop = eot ? cnt : 3'd0;
        end else if (bad) begin
            r.emit = 1'b1;
            r.drop = 3'd1;
        end else begin
            r.emit = 1'b1;
            r.drop = {1'b0, need} + 3'd1;
            case (need)
                2'd0: r.cp = {13'd0, b[0]};
                2'd1: r.cp = {10'd0, b[0][4:0], b[1][5:0]};
                2'd2: r.cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
                default: r.cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
            endcase
        end
        return r;
    endfunction

    function automatic t_held shift_held(t_held b, logic [CNT_W-1:0] k);
        t_held r;
        int j;
        r = b;
        for (int i = 0; i < HELD_N; i++) begin
            j = i + int'(k);
            if (j < HELD_N) begin
                r[i] = b[j[1:0]];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/u8dec_in_if.sv
// Input channel: one text byte with its end-of-text mark per word.
`default_nettype none

interface u8dec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

### rtl/u8dec_out_if.sv
// Output channel: one decoded codepoint with its end-of-run mark per word.
`default_nettype none

interface u8dec_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] codepoint;
    logic        end_of_run;

    modport source (output valid, output codepoint, output end_of_run, input ready);
    modport sink   (input valid, input codepoint, input end_of_run, output ready);
endinterface

`default_nettype wire

### rtl/utf8_codepoint_decoder.sv
// Top level of the UTF-8 codepoint decoder: controller, datapath and checks.
//
//  channel  dir  handshake      word
//  i_in     in   valid/ready    text_byte[7:0], end_of_text
//  o_out    out  valid/ready    codepoint[20:0], end_of_run
//
// A byte is taken in S_IDLE and decoded in the next cycle. A byte that
// completes nothing returns to S_IDLE after its decode pass; a byte with results
// gets an S_EVAL pass and an S_OUT delivery per result found in the held bytes.
// Synchronous active-low reset empties the held bytes and idles the block.
// Output stalls hold the result register; no input is taken meanwhile.
`default_nettype none

module utf8_codepoint_decoder (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    u8dec_in_if.sink     i_in,
    u8dec_out_if.source  o_out
);
    import u8dec_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    u8dec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    u8dec_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_text_byte   (i_in.text_byte),
        .i_end_of_text (i_in.end_of_text),
        .o_codepoint   (o_out.codepoint),
        .o_end_of_run  (o_out.end_of_run)
    );

`ifndef SYNTHESIS
    // input is never open while a result is pending
    a_ready_vs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while result pending");

    // a result is never shown in the cycle right after a byte is taken
    a_eval_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !o_out.valid)
        else $error("result without decode pass");

    // more results of the same byte follow before the next byte is taken
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.end_of_run) |=> !i_in.ready)
        else $error("input reopened inside a run");

    // a new result always comes from a step command
    a_step_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.step))
        else $error("result without step");
`endif
endmodule

`default_nettype wire

### rtl/u8dec_datapath.sv
// Datapath: held byte registers, decode pass with one pass of lookahead, result register.
`default_nettype none

module u8dec_datapath (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire u8dec_pkg::t_dp_cmd      i_cmd,
    output u8dec_pkg::t_dp_sts           o_sts,
    input  wire logic [7:0]              i_text_byte,
    input  wire logic                    i_end_of_text,
    output logic [20:0]                  o_codepoint,
    output logic                         o_end_of_run
);
    import u8dec_pkg::*;

    t_held            r_held;
    logic [CNT_W-1:0] r_cnt;
    logic             r_eot;
    logic [CP_W-1:0]  r_cp;
    logic             r_eor;

    t_eval cur;
    t_eval nxt;
    t_held held_shift;

    always_comb begin
        cur        = eval_lead(r_held, r_cnt, r_eot);
        held_shift = shift_held(r_held, cur.drop);
        // lookahead tells whether this result closes the run
        nxt        = eval_lead(held_shift, r_cnt - cur.drop, r_eot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= r_cnt + 3'd1;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - cur.drop;
        end else if (i_cmd.clear && r_eot) begin
            r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_held[r_cnt[1:0]] <= i_text_byte;
            r_eot              <= i_end_of_text;
        end else if (i_cmd.step) begin
            r_held <= held_shift;
        end
        if (i_cmd.step) begin
            r_cp  <= cur.cp;
            r_eor <= !nxt.emit;
        end
    end

    assign o_sts.emit   = cur.emit;
    assign o_sts.last   = r_eor;
    assign o_codepoint  = r_cp;
    assign o_end_of_run = r_eor;
endmodule

`default_nettype wire

### rtl/u8dec_ctrl.sv
// Controller: sequences accept, decode passes and result delivery.
`default_nettype none

module u8dec_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output u8dec_pkg::t_dp_cmd      o_cmd,
    input  wire u8dec_pkg::t_dp_sts i_sts
);
    import u8dec_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.emit) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = i_sts.last ? S_IDLE : S_EVAL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// Testbench for the UTF-8 codepoint decoder: directed and random byte streams, inline model.
module tb;
    import u8dec_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } t_cp_word;

    logic i_clk;
    logic i_rst_n;

    u8dec_in_if  in_ch ();
    u8dec_out_if out_ch ();

    utf8_codepoint_decoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // decoder state as seen by the bench
    t_cp_word   expected_cps [$];
    logic [7:0] pend_bytes [0:3];
    int         pend_cnt = 0;

    int errors      = 0;
    int bytes_sent  = 0;
    int eot_sent    = 0;
    int cps_checked = 0;
    int repl_seen   = 0;
    int cycles      = 0;

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int hold_len  = 0;
    int hold_id   = 0;
    int hold_seen = 0;
    int rx_wait   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // continuation bytes a lead needs, -1 for a bad lead
    function automatic int cont_needed(input logic [7:0] b);
        if (!b[7]) return 0;
        if ((b & LEAD2_MASK) == LEAD2_VAL) return 1;
        if ((b & LEAD3_MASK) == LEAD3_VAL) return 2;
        if ((b & LEAD4_MASK) == LEAD4_VAL) return 3;
        return -1;
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [31:0] r;
        r = $urandom;
        return {2'b10, r[5:0]};
    endfunction

    task automatic drop_pending(input int k);
        int i;
        if (k >= pend_cnt) begin
            pend_cnt = 0;
        end else begin
            for (i = 0; i + k < pend_cnt; i++) begin
                pend_bytes[i] = pend_bytes[i + k];
            end
            pend_cnt -= k;
        end
    endtask

    task automatic predict_codepoints(input logic [7:0] b, input logic eot);
        logic [CP_W-1:0] cps [0:3];
        logic [CP_W-1:0] cp;
        logic            bad;
        t_cp_word        w;
        int              n;
        int              need;
        int              i;
        n = 0;
        pend_bytes[pend_cnt] = b;
        pend_cnt++;
        while (pend_cnt > 0 && n < 4) begin
            need = cont_needed(pend_bytes[0]);
            if (need < 0) begin
                cps[n] = REPL_CP;
                n++;
                drop_pending(1);
                continue;
            end
            if (pend_cnt < need + 1) begin
                // cut short by end of text: one replacement covers all held bytes
                if (eot) begin
                    cps[n] = REPL_CP;
                    n++;
                    pend_cnt = 0;
                end
                break;
            end
            case (need)
                0: cp = {13'd0, pend_bytes[0]};
                1: cp = {16'd0, pend_bytes[0][4:0]};
                2: cp = {17'd0, pend_bytes[0][3:0]};
                default: cp = {18'd0, pend_bytes[0][2:0]};
            endcase
            bad = 1'b0;
            for (i = 1; i <= need; i++) begin
                if ((pend_bytes[i] & CONT_MASK) != CONT_VAL) bad = 1'b1;
                cp = {cp[CP_W-7:0], pend_bytes[i][5:0]};
            end
            if (bad) begin
                // only the lead is consumed; the rest are retried as leads
                cps[n] = REPL_CP;
                n++;
                drop_pending(1);
            end else begin
                cps[n] = cp;
                n++;
                drop_pending(need + 1);
            end
        end
        if (eot) pend_cnt = 0;
        for (i = 0; i < n; i++) begin
            w.cp   = cps[i];
            w.last = (i == n - 1);
            expected_cps.push_back(w);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.text_byte   <= b;
        in_ch.end_of_text <= eot;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_codepoints(b, eot);
        bytes_sent++;
        if (eot) eot_sent++;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender pause: nothing offered until every codepoint is out
    task automatic wait_all_decoded();
        in_ch.valid <= 1'b0;
        while (expected_cps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // well-formed character of len bytes with random payload
    task automatic send_char(input int len, input logic eot);
        logic [31:0] r;
        logic [7:0]  lead;
        int          i;
        r = $urandom;
        case (len)
            1: lead = {1'b0, r[6:0]};
            2: lead = {3'b110, r[4:0]};
            3: lead = {4'b1110, r[3:0]};
            default: lead = {5'b11110, r[2:0]};
        endcase
        send_byte(lead, eot && len == 1);
        for (i = 1; i < len; i++) begin
            send_byte(cont_byte(), eot && i == len - 1);
        end
    endtask

    // lead with too few continuations: cut by end of text or by a non-continuation
    task automatic send_broken();
        logic [31:0] r;
        logic [7:0]  b;
        int          len;
        int          k;
        int          i;
        bit          cut;
        len = $urandom_range(2, 4);
        k   = $urandom_range(0, len - 2);
        cut = $urandom_range(0, 1);
        r   = $urandom;
        case (len)
            2: b = {3'b110, r[4:0]};
            3: b = {4'b1110, r[3:0]};
            default: b = {5'b11110, r[2:0]};
        endcase
        send_byte(b, cut && k == 0);
        for (i = 1; i <= k; i++) begin
            send_byte(cont_byte(), cut && i == k);
        end
        if (!cut) begin
            r = $urandom;
            b = r[7:0];
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            send_byte(b, $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic test_single_byte();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h41, 1'b1);
        wait_all_decoded();
    endtask

    task automatic test_sequence_extremes();
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        wait_all_decoded();
    endtask

    task automatic test_invalid_leads();
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_all_decoded();
    endtask

    task automatic test_bad_continuation();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
        // four words from one byte: replacement, then three retried leads
        send_byte(8'hF0, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b0);
        wait_all_decoded();
    endtask

    task automatic test_cut_by_end();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hC3, 1'b1);
        wait_all_decoded();
    endtask

    task automatic test_unchecked_forms();
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b0);
        wait_all_decoded();
    endtask

    task automatic test_random_text(input int n_bytes);
        int start;
        int r;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_char($urandom_range(1, 4), $urandom_range(0, 11) == 0);
            end else if (r < 82) begin
                r = $urandom;
                send_byte(r[7:0], $urandom_range(0, 7) == 0);
            end else begin
                send_broken();
            end
        end
        wait_all_decoded();
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_output_hold();
        int i;
        tx_steady = 1'b1;
        hold_len  = 300;
        hold_id++;
        for (i = 0; i < 7; i++) begin
            send_char($urandom_range(3, 4), 1'b0);
        end
        wait_all_decoded();
        tx_steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_wait = 0;
        end else if (hold_id != hold_seen) begin
            hold_seen = hold_id;
            rx_wait = hold_len - 1;
            out_ch.ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            out_ch.ready <= 1'b0;
        end else if (!rx_steady && $urandom_range(0, 99) < 30) begin
            rx_wait = idle_len();
            out_ch.ready <= (rx_wait == 0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : cp_check
        t_cp_word w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_cps.size() == 0) begin
                errors++;
                $error("codepoint: none expected, got %h (end_of_run %b)",
                       out_ch.codepoint, out_ch.end_of_run);
            end else begin
                w = expected_cps.pop_front();
                if (out_ch.codepoint !== w.cp) begin
                    errors++;
                    $error("codepoint: expected %h, got %h", w.cp, out_ch.codepoint);
                end
                if (out_ch.end_of_run !== w.last) begin
                    errors++;
                    $error("end_of_run: expected %b, got %b", w.last, out_ch.end_of_run);
                end
                cps_checked++;
                if (w.cp == REPL_CP) repl_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.text_byte   = 8'h00;
        in_ch.end_of_text = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_byte();
        test_sequence_extremes();
        test_invalid_leads();
        test_bad_continuation();
        test_cut_by_end();
        test_unchecked_forms();
        test_random_text(40);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        test_random_text(25);
        tx_steady = 1'b0;
        test_random_text(15);
        rx_steady = 1'b0;
        test_output_hold();
        test_random_text(30);

        wait_all_decoded();
        repeat (10) @(posedge i_clk);
        $display("tb: %0d bytes in (%0d ending a text), %0d codepoints checked, %0d replacements",
                 bytes_sent, eot_sent, cps_checked, repl_seen);
        $display("tb: covered bad leads, bad continuations, cut-off texts and a long output hold");
        if (errors == 0 && expected_cps.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
rtl/u8dec_pkg.sv
rtl/u8dec_in_if.sv
rtl/u8dec_out_if.sv
rtl/u8dec_datapath.sv
rtl/u8dec_ctrl.sv
rtl/utf8_codepoint_decoder.sv
bench/tb.sv
